### hdl/fpf_pkg.sv
// ----------------------------------------------------------------------------
// Framebuffer fill engine package
// Shared constants and the command and result transaction types.
// ----------------------------------------------------------------------------
package fpf_pkg;

  localparam int CANVAS_WIDTH_DEF  = 600;
  localparam int CANVAS_HEIGHT_DEF = 400;

  localparam int PIX_W   = 24;
  localparam int CHAN_W  = 8;
  localparam int NCHAN   = 3;
  localparam int COORD_W = 12;
  localparam int NUM_W   = 20;

  localparam logic [2:0] ACT_PIXEL    = 3'd0;
  localparam logic [2:0] ACT_HSPAN    = 3'd1;
  localparam logic [2:0] ACT_VSPAN    = 3'd2;
  localparam logic [2:0] ACT_RECT     = 3'd3;
  localparam logic [2:0] ACT_DISK     = 3'd4;
  localparam logic [2:0] ACT_GRADIENT = 3'd5;
  localparam logic [2:0] ACT_READ     = 3'd6;
  localparam logic [2:0] ACT_UNDEF    = 3'd7;

  typedef struct packed {
    logic [2:0]                action;
    logic signed [COORD_W-1:0] x_first;
    logic signed [COORD_W-1:0] y_first;
    logic signed [COORD_W-1:0] x_second;
    logic signed [COORD_W-1:0] y_second;
    logic [9:0]                radius;
    logic [PIX_W-1:0]          color_a;
    logic [PIX_W-1:0]          color_b;
  } cmd_t;

  typedef struct packed {
    logic             rejected;
    logic [PIX_W-1:0] pixel_color;
  } res_t;

endpackage

### hdl/framebuffer_primitive_fill.sv
// ----------------------------------------------------------------------------
// Framebuffer fill engine
// Draws pixels, spans, rectangles, disks and gradients into a pixel store
// and reads single pixels back, one command at a time.
// ----------------------------------------------------------------------------
// A command visits its rows and each row's pixels, then ends in a done state;
// disks first square the radius and first column offset, gradients first form
// three channel numerators, and each canvas pixel of a nonzero-length gradient
// waits for the divider. A read passes two read states. One command at a time:
// busy stays high through the done state, done is high for a single cycle and
// the result holds until the next command. Reset clears every pixel, busy high.
module framebuffer_primitive_fill #(
  parameter int CANVAS_WIDTH  = fpf_pkg::CANVAS_WIDTH_DEF,
  parameter int CANVAS_HEIGHT = fpf_pkg::CANVAS_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  fpf_pkg::cmd_t cmd,
  output logic          done,
  output fpf_pkg::res_t result
);

  localparam int DEPTH  = CANVAS_WIDTH * CANVAS_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic signed [12:0] W13 = 13'(CANVAS_WIDTH);
  localparam logic signed [12:0] H13 = 13'(CANVAS_HEIGHT);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_RR    = 4'd2;
  localparam logic [3:0] ST_DX0   = 4'd3;
  localparam logic [3:0] ST_GNUM  = 4'd4;
  localparam logic [3:0] ST_ROW   = 4'd5;
  localparam logic [3:0] ST_ROWSQ = 4'd6;
  localparam logic [3:0] ST_PIX   = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_RD1   = 4'd9;
  localparam logic [3:0] ST_RD2   = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_DISK  = 2'd1;
  localparam logic [1:0] MODE_GRAD  = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  function automatic logic in_x(input logic signed [12:0] v);
    return (v >= 13'sd0) && (v < W13);
  endfunction

  function automatic logic in_y(input logic signed [12:0] v);
    return (v >= 13'sd0) && (v < H13);
  endfunction

  logic [3:0]               state;
  logic [1:0]               mode;
  logic signed [12:0]       cur_x, cur_y, xlo, xhi, yhi, xc, yc, rad, dx;
  logic [fpf_pkg::PIX_W-1:0] col_a, col_b;
  logic [11:0]              span;
  logic [20:0]              rr, dx0sq, dx2, dy2;
  logic [ADDR_W-1:0]        base, clr_cnt;
  logic [1:0]               gch;
  logic [fpf_pkg::NCHAN-1:0][fpf_pkg::NUM_W-1:0] num;
  fpf_pkg::res_t            res;

  logic signed [12:0] xf, yf, xs, ys, rs, xmin, xmax, ymin, ymax, ytop;
  logic signed [12:0] d_xlo, d_xhi, d_ylo, d_yhi, d_diff;
  logic [1:0]         d_mode;
  logic               d_rej, d_draw;
  logic [3:0]         d_next;

  logic signed [12:0] ma, mb;
  logic signed [25:0] prod;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [fpf_pkg::PIX_W-1:0] mem_wdata, mem_rdata;
  logic               div_start, div_done;
  logic [fpf_pkg::PIX_W-1:0] div_quot;

  logic               pix_in, disk_hit, advance, go_div;
  logic [21:0]        dsum;

  always_comb begin
    xf   = 13'(cmd.x_first);
    yf   = 13'(cmd.y_first);
    xs   = 13'(cmd.x_second);
    ys   = 13'(cmd.y_second);
    rs   = 13'({1'b0, cmd.radius});
    xmin = (xf < xs) ? xf : xs;
    xmax = (xf < xs) ? xs : xf;
    ymin = (yf < ys) ? yf : ys;
    ymax = (yf < ys) ? ys : yf;
    ytop = ymax - 13'sd1;
    d_diff = xmax - xmin;
    d_xlo = xmin;
    d_xhi = xmax;
    d_ylo = yf;
    d_yhi = yf;
    d_mode = MODE_PLAIN;
    d_rej = 1'b0;
    d_draw = 1'b0;
    case (cmd.action)
      fpf_pkg::ACT_PIXEL: begin
        d_xlo = xf;
        d_xhi = xf;
        d_draw = in_x(xf) && in_y(yf);
      end
      fpf_pkg::ACT_HSPAN: begin
        d_rej = !(in_y(yf) && in_x(xf) && in_x(xs));
        d_draw = !d_rej;
      end
      fpf_pkg::ACT_VSPAN: begin
        d_xlo = xf;
        d_xhi = xf;
        d_ylo = ymin;
        d_yhi = ymax;
        d_rej = (xf < 13'sd0) || !in_y(yf) || !in_y(ys);
        d_draw = !d_rej && (xf < W13);
      end
      fpf_pkg::ACT_RECT: begin
        d_ylo = (ymin < 13'sd0) ? 13'sd0 : ymin;
        d_yhi = (ytop >= H13) ? (H13 - 13'sd1) : ytop;
        d_rej = (ymin < ymax) &&
                (!(in_x(xf) && in_x(xs)) || (ymin < 13'sd0) || (ytop >= H13));
        d_draw = (ymin < ymax) && in_x(xf) && in_x(xs) && (d_ylo <= d_yhi);
      end
      fpf_pkg::ACT_DISK: begin
        d_mode = MODE_DISK;
        d_ylo = ((yf - rs) < 13'sd0) ? 13'sd0 : (yf - rs);
        d_yhi = ((yf + rs) >= H13) ? (H13 - 13'sd1) : (yf + rs);
        d_xlo = ((xf - rs) < 13'sd0) ? 13'sd0 : (xf - rs);
        d_xhi = ((xf + rs) >= W13) ? (W13 - 13'sd1) : (xf + rs);
        d_draw = (d_ylo <= d_yhi) && (d_xlo <= d_xhi);
      end
      fpf_pkg::ACT_GRADIENT: begin
        d_mode = MODE_GRAD;
        d_draw = in_y(yf);
      end
      fpf_pkg::ACT_READ: begin
        d_mode = MODE_READ;
        d_xlo = xf;
        d_draw = in_x(xf) && in_y(yf);
      end
      default: begin
        d_draw = 1'b0;
      end
    endcase
    if (!d_draw) begin
      d_next = ST_DONE;
    end else if (d_mode == MODE_DISK) begin
      d_next = ST_RR;
    end else if ((d_mode == MODE_GRAD) && (d_diff != 13'sd0)) begin
      d_next = ST_GNUM;
    end else begin
      d_next = ST_ROW;
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_RR: begin
        ma = rad;
        mb = rad;
      end
      ST_DX0: begin
        ma = xlo - xc;
        mb = xlo - xc;
      end
      ST_GNUM: begin
        ma = 13'({1'b0, span});
        mb = 13'({5'd0, col_b[gch*fpf_pkg::CHAN_W +: fpf_pkg::CHAN_W]});
      end
      ST_ROW: begin
        ma = cur_y;
        mb = W13;
      end
      ST_ROWSQ: begin
        ma = cur_y - yc;
        mb = cur_y - yc;
      end
      default: begin
        ma = '0;
      end
    endcase
    prod = ma * mb;
  end

  always_comb begin
    pix_in   = in_x(cur_x);
    dsum     = {1'b0, dx2} + {1'b0, dy2};
    disk_hit = dsum <= {1'b0, rr};
    go_div   = (state == ST_PIX) && (mode == MODE_GRAD) && pix_in && (span != 12'd0);
    div_start = go_div;
    advance  = ((state == ST_PIX) && !go_div) || ((state == ST_DIV) && div_done);
    mem_we    = 1'b0;
    mem_wdata = col_a;
    mem_addr  = base + ADDR_W'(cur_x[10:0]);
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt;
        mem_wdata = '0;
      end
      ST_PIX: begin
        case (mode)
          MODE_DISK: mem_we = disk_hit;
          MODE_GRAD: mem_we = pix_in && (span == 12'd0);
          default:   mem_we = 1'b1;
        endcase
      end
      ST_DIV: begin
        mem_we    = div_done;
        mem_wdata = div_quot;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      gch     <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state <= d_next;
            gch   <= '0;
          end
        end
        ST_RR:    state <= ST_DX0;
        ST_DX0:   state <= ST_ROW;
        ST_GNUM: begin
          gch <= gch + 2'd1;
          if (gch == 2'd2) begin
            state <= ST_ROW;
          end
        end
        ST_ROW: begin
          case (mode)
            MODE_READ: state <= ST_RD1;
            MODE_DISK: state <= ST_ROWSQ;
            default:   state <= ST_PIX;
          endcase
        end
        ST_ROWSQ: state <= ST_PIX;
        ST_PIX: begin
          if (go_div) begin
            state <= ST_DIV;
          end else if (cur_x == xhi) begin
            state <= (cur_y == yhi) ? ST_DONE : ST_ROW;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (cur_x == xhi) begin
              state <= (cur_y == yhi) ? ST_DONE : ST_ROW;
            end else begin
              state <= ST_PIX;
            end
          end
        end
        ST_RD1:  state <= ST_RD2;
        ST_RD2:  state <= ST_DONE;
        ST_DONE: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          mode  <= d_mode;
          cur_y <= d_ylo;
          yhi   <= d_yhi;
          xlo   <= d_xlo;
          xhi   <= d_xhi;
          xc    <= xf;
          yc    <= yf;
          rad   <= rs;
          col_a <= cmd.color_a;
          col_b <= cmd.color_b;
          span  <= d_diff[11:0];
        end
      end
      ST_RR:  rr    <= prod[20:0];
      ST_DX0: dx0sq <= prod[20:0];
      ST_GNUM: num[gch] <= prod[fpf_pkg::NUM_W-1:0];
      ST_ROW: begin
        base  <= ADDR_W'(prod);
        cur_x <= xlo;
        dx    <= xlo - xc;
        dx2   <= dx0sq;
      end
      ST_ROWSQ: dy2 <= prod[20:0];
      default: ;
    endcase
    if (advance) begin
      if (cur_x == xhi) begin
        cur_y <= cur_y + 13'sd1;
      end else begin
        cur_x <= cur_x + 13'sd1;
      end
      dx  <= dx + 13'sd1;
      dx2 <= dx2 + {{7{dx[12]}}, dx, 1'b1};
      for (int c = 0; c < fpf_pkg::NCHAN; c++) begin
        num[c] <= num[c]
                + fpf_pkg::NUM_W'({1'b0, col_a[c*fpf_pkg::CHAN_W +: fpf_pkg::CHAN_W]})
                - fpf_pkg::NUM_W'({1'b0, col_b[c*fpf_pkg::CHAN_W +: fpf_pkg::CHAN_W]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res <= '0;
    end else if ((state == ST_IDLE) && start) begin
      res.rejected    <= d_rej;
      res.pixel_color <= '0;
    end else if (state == ST_RD2) begin
      res.pixel_color <= mem_rdata;
    end
  end

  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_DONE);
  assign result = res;

  fpf_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  fpf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (span),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule

### hdl/fpf_store.sv
// ----------------------------------------------------------------------------
// Frame store
// Single-port pixel memory with a registered read.
// ----------------------------------------------------------------------------
module fpf_store #(
  parameter int DEPTH  = fpf_pkg::CANVAS_WIDTH_DEF * fpf_pkg::CANVAS_HEIGHT_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         addr,
  input  logic [fpf_pkg::PIX_W-1:0] wdata,
  output logic [fpf_pkg::PIX_W-1:0] rdata
);

  logic [fpf_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hdl/fpf_div.sv
// ----------------------------------------------------------------------------
// Gradient channel divider
// Restoring division of three channel numerators by one span, one
// quotient bit per cycle into an eight-bit quotient per channel.
// ----------------------------------------------------------------------------
module fpf_div (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  logic [fpf_pkg::NCHAN-1:0][fpf_pkg::NUM_W-1:0] num,
  input  logic [fpf_pkg::COORD_W-1:0]                   den,
  output logic                                          done,
  output logic [fpf_pkg::PIX_W-1:0]                     quot
);

  logic [3:0] cnt;
  logic [fpf_pkg::NCHAN-1:0][fpf_pkg::COORD_W-1:0] rem;
  logic [fpf_pkg::NCHAN-1:0][fpf_pkg::CHAN_W-1:0]  low;
  logic [fpf_pkg::NCHAN-1:0][fpf_pkg::COORD_W:0]   trial;
  logic [fpf_pkg::NCHAN-1:0]                       fits;

  always_comb begin
    for (int c = 0; c < fpf_pkg::NCHAN; c++) begin
      trial[c] = {rem[c], low[c][fpf_pkg::CHAN_W-1]};
      fits[c]  = trial[c] >= {1'b0, den};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= 4'd8;
      end else if (cnt != 4'd0) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < fpf_pkg::NCHAN; c++) begin
      if (start) begin
        rem[c] <= num[c][fpf_pkg::NUM_W-1:fpf_pkg::CHAN_W];
        low[c] <= num[c][fpf_pkg::CHAN_W-1:0];
      end else if (cnt != 4'd0) begin
        rem[c] <= fits[c] ? fpf_pkg::COORD_W'(trial[c] - {1'b0, den})
                          : trial[c][fpf_pkg::COORD_W-1:0];
        low[c] <= {low[c][fpf_pkg::CHAN_W-2:0], fits[c]};
      end
    end
  end

  assign quot = low;

endmodule

### tb/tb_framebuffer_primitive_fill.sv
// ----------------------------------------------------------------------------
// Framebuffer fill engine testbench
// Sends directed and random drawing commands with random gaps, keeps its own
// copy of the canvas to predict each result, and checks every done strobe.
// ----------------------------------------------------------------------------
module tb_framebuffer_primitive_fill;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = fpf_pkg::CANVAS_WIDTH_DEF;
  localparam int H = fpf_pkg::CANVAS_HEIGHT_DEF;
  localparam int NUM_RANDOM = 1700;
  localparam int DRAIN_AT = 850;
  localparam longint CYCLE_LIMIT = 8000000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  fpf_pkg::cmd_t cmd;
  logic done;
  fpf_pkg::res_t result;

  bit [fpf_pkg::PIX_W-1:0] canvas [W*H];
  fpf_pkg::cmd_t pending_cmds [$];
  fpf_pkg::res_t expected_results [$];
  int total_cmds;
  int accepted_cmds;
  int gap_left;
  int error_count;
  int reject_count;
  int action_count [8];
  longint cycle_count;

  framebuffer_primitive_fill uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit on_canvas(int x, int y);
    return x >= 0 && x < W && y >= 0 && y < H;
  endfunction

  function automatic void paint_pixel(int x, int y, bit [fpf_pkg::PIX_W-1:0] c);
    if (on_canvas(x, y)) canvas[y*W + x] = c;
  endfunction

  function automatic bit draw_row(int y, int xa, int xb, bit [fpf_pkg::PIX_W-1:0] c);
    int lo;
    int hi;
    lo = xa < xb ? xa : xb;
    hi = xa < xb ? xb : xa;
    if (y < 0 || y >= H || lo < 0 || hi >= W) return 1'b1;
    for (int k = lo; k <= hi; k++) paint_pixel(k, y, c);
    return 1'b0;
  endfunction

  function automatic void draw_ramp(int y, int xa, int xb, bit [fpf_pkg::PIX_W-1:0] ca,
                                    bit [fpf_pkg::PIX_W-1:0] cb);
    int x0;
    int x1;
    int len;
    bit [fpf_pkg::PIX_W-1:0] col;
    int v;
    x0 = xa < xb ? xa : xb;
    x1 = xa < xb ? xb : xa;
    len = x1 - x0;
    if (y < 0 || y >= H) return;
    for (int i = x0; i <= x1; i++) begin
      if (i < 0 || i >= W) continue;
      if (len == 0) begin
        col = ca;
      end else begin
        for (int ch = 0; ch < fpf_pkg::NCHAN; ch++) begin
          v = ((i - x0) * int'(ca[ch*8 +: 8]) + (x1 - i) * int'(cb[ch*8 +: 8])) / len;
          if (v > 255) v = 255;
          col[ch*8 +: 8] = v[7:0];
        end
      end
      paint_pixel(i, y, col);
    end
  endfunction

  function automatic fpf_pkg::res_t apply_command(fpf_pkg::cmd_t c);
    fpf_pkg::res_t r;
    int xf;
    int yf;
    int xs;
    int ys;
    int rad;
    longint dx;
    longint dy;
    r = '0;
    xf = int'(c.x_first);
    yf = int'(c.y_first);
    xs = int'(c.x_second);
    ys = int'(c.y_second);
    rad = int'(c.radius);
    case (c.action)
      fpf_pkg::ACT_PIXEL: paint_pixel(xf, yf, c.color_a);
      fpf_pkg::ACT_HSPAN: r.rejected = draw_row(yf, xf, xs, c.color_a);
      fpf_pkg::ACT_VSPAN: begin
        if (xf < 0 || yf < 0 || yf >= H || ys < 0 || ys >= H) begin
          r.rejected = 1'b1;
        end else begin
          for (int k = (yf < ys ? yf : ys); k <= (yf < ys ? ys : yf); k++)
            paint_pixel(xf, k, c.color_a);
        end
      end
      fpf_pkg::ACT_RECT: begin
        for (int k = (yf < ys ? yf : ys); k < (yf < ys ? ys : yf); k++)
          if (draw_row(k, xf, xs, c.color_a)) r.rejected = 1'b1;
      end
      fpf_pkg::ACT_DISK: begin
        for (int i = (yf - rad > 0 ? yf - rad : 0);
             i <= (yf + rad < H - 1 ? yf + rad : H - 1); i++)
          for (int j = (xf - rad > 0 ? xf - rad : 0);
               j <= (xf + rad < W - 1 ? xf + rad : W - 1); j++) begin
            dy = i - yf;
            dx = j - xf;
            if (dy*dy + dx*dx <= longint'(rad)*rad) paint_pixel(j, i, c.color_a);
          end
      end
      fpf_pkg::ACT_GRADIENT: draw_ramp(yf, xf, xs, c.color_a, c.color_b);
      fpf_pkg::ACT_READ: if (on_canvas(xf, yf)) r.pixel_color = canvas[yf*W + xf];
      default: ;
    endcase
    return r;
  endfunction

  function automatic fpf_pkg::cmd_t make_cmd(logic [2:0] a, int xf, int yf, int xs,
                                             int ys, int rad,
                                             bit [fpf_pkg::PIX_W-1:0] ca,
                                             bit [fpf_pkg::PIX_W-1:0] cb);
    fpf_pkg::cmd_t c;
    c.action = a;
    c.x_first = xf[fpf_pkg::COORD_W-1:0];
    c.y_first = yf[fpf_pkg::COORD_W-1:0];
    c.x_second = xs[fpf_pkg::COORD_W-1:0];
    c.y_second = ys[fpf_pkg::COORD_W-1:0];
    c.radius = rad[9:0];
    c.color_a = ca;
    c.color_b = cb;
    return c;
  endfunction

  // Coordinates cluster near the low and high borders so that reads find
  // freshly drawn pixels and the edge checks are exercised often.
  function automatic int near_border(int size);
    if ($urandom_range(0, 1)) return $urandom_range(0, 40) - 6;
    return size - 34 + $urandom_range(0, 40);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("mismatch in %s at cycle %0d: got %h, expected %h", what, cycle_count,
             got, want);
  endtask

  always @(posedge clk) begin
    bit accepted;
    bit next_start;
    accepted = 1'b0;
    next_start = 1'b0;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        expected_results.push_back(apply_command(cmd));
        action_count[cmd.action]++;
        accepted_cmds++;
        gap_left = ((accepted_cmds / 64) % 4 == 1) ? 0 : $urandom_range(0, 7);
      end
      if (start && !accepted) begin
        next_start = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_cmds.size() > 0 &&
                   !(accepted_cmds == DRAIN_AT && expected_results.size() > 0)) begin
        cmd <= pending_cmds.pop_front();
        next_start = 1'b1;
      end
      start <= next_start;
    end
  end

  always @(posedge clk) begin
    fpf_pkg::res_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", int'(result), 0);
      end else begin
        want = expected_results.pop_front();
        if (want.rejected) reject_count++;
        if (result.rejected !== want.rejected)
          report_mismatch("rejected", int'(result.rejected), int'(want.rejected));
        if (result.pixel_color !== want.pixel_color)
          report_mismatch("pixel_color", int'(result.pixel_color),
                          int'(want.pixel_color));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_framebuffer_primitive_fill: errors");
      $finish;
    end
  end

  initial begin
    int xf;
    int yf;
    int xs;
    int ys;
    int rad;
    int a;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    error_count = 0;
    reject_count = 0;
    accepted_cmds = 0;
    cycle_count = 0;

    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_PIXEL, 0, 0, 0, 0, 0, 24'hFFFFFF, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_PIXEL, W-1, H-1, 0, 0, 0, 24'h123456, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_PIXEL, -1, 0, 0, 0, 0, 24'hABCDEF, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_PIXEL, -2048, 2047, 2047, -2048, 1023,
                                    24'hFFFFFF, 24'hFFFFFF));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_READ, W-1, H-1, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_READ, 2047, -2048, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_HSPAN, 0, 0, W-1, 0, 0, 24'h00FF00, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_HSPAN, 10, 1, 3, 0, 0, 24'h0000FF, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_HSPAN, 5, 2, W, 0, 0, 24'h111111, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_HSPAN, 5, -1, 8, 0, 0, 24'h111111, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_VSPAN, 5, 10, 0, 2, 0, 24'hFF0000, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_VSPAN, W, 3, 0, 6, 0, 24'h222222, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_VSPAN, -1, 3, 0, 6, 0, 24'h222222, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_VSPAN, 7, 3, 0, H, 0, 24'h222222, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_RECT, 7, 9, 2, 2, 0, 24'h00FFFF, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_RECT, 2, 4, 9, 4, 0, 24'h333333, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_RECT, 20, -2, 25, 3, 0, 24'h444444, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_DISK, 3, 3, 0, 0, 5, 24'hFF00FF, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_DISK, 50, 50, 0, 0, 0, 24'h555555, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_DISK, W/2, H/2, 0, 0, 1023,
                                    24'h666666, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_GRADIENT, 0, 2, W-1, 0, 0, 24'hFF8000,
                                    24'h0080FF));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_GRADIENT, 9, 3, 9, 0, 0, 24'h777777,
                                    24'h1));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_GRADIENT, 20, 4, -10, 0, 0,
                                    24'hFFFFFF, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_GRADIENT, 0, -1, 9, 0, 0,
                                    24'hFFFFFF, 0));
    pending_cmds.push_back(make_cmd(fpf_pkg::ACT_UNDEF, 1, 1, 1, 1, 1, 24'hFFFFFF,
                                    24'hFFFFFF));

    for (int n = 0; n < NUM_RANDOM; n++) begin
      a = $urandom_range(0, 9);
      if (a > int'(fpf_pkg::ACT_UNDEF)) a = fpf_pkg::ACT_READ;
      xf = near_border(W);
      yf = near_border(H);
      xs = xf + $urandom_range(0, 24) - 12;
      ys = yf + $urandom_range(0, 24) - 12;
      rad = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < 3) begin
        // Full-range coordinates; the rectangle stays a few rows tall.
        xf = $urandom_range(0, 4095) - 2048;
        yf = $urandom_range(0, 4095) - 2048;
        xs = $urandom_range(0, 4095) - 2048;
        ys = (a == fpf_pkg::ACT_RECT) ? yf + $urandom_range(0, 4)
                                      : $urandom_range(0, 4095) - 2048;
      end else if ($urandom_range(0, 9) == 0) begin
        // Any radius, with the center far enough left that nothing is visited.
        rad = $urandom_range(0, 1023);
        xf = -2048;
      end
      pending_cmds.push_back(make_cmd(a[2:0], xf, yf, xs, ys, rad, 24'($urandom),
                                      24'($urandom)));
    end
    total_cmds = pending_cmds.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    wait (accepted_cmds == total_cmds && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("%0d commands: %0d pixel, %0d hspan, %0d vspan, %0d rect, %0d disk,",
             total_cmds, action_count[fpf_pkg::ACT_PIXEL],
             action_count[fpf_pkg::ACT_HSPAN], action_count[fpf_pkg::ACT_VSPAN],
             action_count[fpf_pkg::ACT_RECT], action_count[fpf_pkg::ACT_DISK]);
    $display("%0d gradient, %0d read, %0d undefined; %0d results were refusals.",
             action_count[fpf_pkg::ACT_GRADIENT], action_count[fpf_pkg::ACT_READ],
             action_count[fpf_pkg::ACT_UNDEF], reject_count);
    if (error_count == 0) begin
      $display("tb_framebuffer_primitive_fill: clean");
    end else begin
      $display("tb_framebuffer_primitive_fill: errors");
    end
    $finish;
  end

endmodule
